// ===== hw/rtl/unicode_char_class_flags_top_assert.svh =====
// Assertion macros used by the character classification top module.
`ifndef UNICODE_CHAR_CLASS_FLAGS_TOP_ASSERT_SVH
`define UNICODE_CHAR_CLASS_FLAGS_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UCF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ucf assertion failed");

// The consequent must hold from the cycle after the antecedent.
`define UCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ucf assertion failed");

`endif

// ===== hw/rtl/ucf_pkg.sv =====
package ucf_pkg;

   localparam int DigitBlocks = 36;

   localparam logic [20:0] DIGIT_STARTS [DigitBlocks] = '{
      21'h00660, 21'h006F0, 21'h007C0, 21'h00966, 21'h009E6, 21'h00A66,
      21'h00AE6, 21'h00B66, 21'h00BE6, 21'h00C66, 21'h00CE6, 21'h00D66,
      21'h00DE6, 21'h00E50, 21'h00ED0, 21'h00F20, 21'h01040, 21'h01090,
      21'h017E0, 21'h01810, 21'h01946, 21'h019D0, 21'h01A80, 21'h01A90,
      21'h01B50, 21'h01BB0, 21'h01C40, 21'h01C50, 21'h0A620, 21'h0A8D0,
      21'h0A900, 21'h0A9D0, 21'h0A9F0, 21'h0AA50, 21'h0ABF0, 21'h0FF10
   };

   typedef struct packed {
      logic [20:0] code_point;
      logic        has_upper_mapping;
      logic        has_lower_mapping;
   } req_type;

   typedef struct packed {
      logic is_letter;
      logic is_decimal;
      logic is_letter_or_digit;
      logic is_whitespace;
      logic is_blank_char;
      logic is_control;
      logic is_printable;
      logic is_graphic;
      logic is_punctuation;
      logic is_hex_digit;
   } rsp_type;

   function automatic logic in_rng(logic [20:0] c, logic [20:0] lo, logic [20:0] hi);
      return (c >= lo) && (c <= hi);
   endfunction

   function automatic logic decimal_flag(logic [20:0] c);
      logic        hit;
      logic [20:0] diff;
      hit = in_rng(c, 21'h30, 21'h39);
      for (int i = 0; i < DigitBlocks; i++) begin
         diff = c - DIGIT_STARTS[i];
         if (diff < 21'd10) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   function automatic logic letter_flag(logic [20:0] c, logic up, logic low);
      logic res;
      if (c < 21'h80) begin
         res = in_rng(c, 21'h41, 21'h5A) || in_rng(c, 21'h61, 21'h7A);
      end else begin
         res = up || low ||
               in_rng(c, 21'h0100, 21'h02AF) || in_rng(c, 21'h0370, 21'h0373) ||
               in_rng(c, 21'h0376, 21'h0377) || in_rng(c, 21'h037A, 21'h037D) ||
               (c == 21'h037F) ||
               (in_rng(c, 21'h0386, 21'h03FF) && (c != 21'h0387)) ||
               in_rng(c, 21'h0400, 21'h052F);
      end
      return res;
   endfunction

   function automatic logic space_flag(logic [20:0] c);
      logic res;
      if (c < 21'h80) begin
         res = (c == 21'h20) || in_rng(c, 21'h09, 21'h0D);
      end else begin
         res = (c == 21'h00A0) || (c == 21'h1680) || (c == 21'h2028) ||
               (c == 21'h2029) || (c == 21'h202F) || (c == 21'h205F) ||
               (c == 21'h3000) || in_rng(c, 21'h2000, 21'h200A);
      end
      return res;
   endfunction

   function automatic logic control_flag(logic [20:0] c);
      return (c <= 21'h1F) || in_rng(c, 21'h7F, 21'h9F);
   endfunction

   function automatic logic punct_flag(logic [20:0] c);
      logic res;
      if (c < 21'h80) begin
         res = in_rng(c, 21'h21, 21'h2F) || in_rng(c, 21'h3A, 21'h40) ||
               in_rng(c, 21'h5B, 21'h60) || in_rng(c, 21'h7B, 21'h7E);
      end else begin
         res = (c == 21'hA1) || (c == 21'hA7) || (c == 21'hAB) || (c == 21'hB6) ||
               (c == 21'hB7) || (c == 21'hBB) || (c == 21'hBF) ||
               in_rng(c, 21'h2010, 21'h2027) || in_rng(c, 21'h2030, 21'h205E);
      end
      return res;
   endfunction

   function automatic logic hex_flag(logic [20:0] c);
      return in_rng(c, 21'h30, 21'h39) || in_rng(c, 21'h41, 21'h46) ||
             in_rng(c, 21'h61, 21'h66);
   endfunction

   function automatic rsp_type classify(req_type r);
      rsp_type o;
      logic    hidden;
      o.is_letter          = letter_flag(r.code_point, r.has_upper_mapping,
                                         r.has_lower_mapping);
      o.is_decimal         = decimal_flag(r.code_point);
      o.is_letter_or_digit = o.is_letter || o.is_decimal;
      o.is_whitespace      = space_flag(r.code_point);
      o.is_blank_char      = (r.code_point == 21'h20) || (r.code_point == 21'h09);
      o.is_control         = control_flag(r.code_point);
      hidden = in_rng(r.code_point, 21'h200B, 21'h200F) ||
               in_rng(r.code_point, 21'h202A, 21'h202E) ||
               in_rng(r.code_point, 21'h2060, 21'h2064) ||
               (r.code_point == 21'hFEFF);
      o.is_printable       = !o.is_control && !hidden;
      o.is_graphic         = o.is_printable && !o.is_whitespace;
      o.is_punctuation     = punct_flag(r.code_point);
      o.is_hex_digit       = hex_flag(r.code_point);
      return o;
   endfunction

endpackage

// ===== hw/rtl/unicode_char_class_flags_top.sv =====
// Channel   Ports                       Width  Direction
// request   start, busy, req_data       23     in (busy out)
// response  rsp_strobe, rsp_data        10     out
//
// One word is taken in every cycle in which start is high and busy is low.
// A word that is taken is registered in req_ff, classified from there into the result
// register rsp_ff, and driven on the ports from rsp_ff together with rsp_strobe.
// Busy is high only while reset is applied and until a clock edge without reset clears it.
// The receiver cannot stall, so each result is shown for exactly one cycle.
`include "unicode_char_class_flags_top_assert.svh"

module unicode_char_class_flags_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ucf_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output ucf_pkg::rsp_type  rsp_data
);

   logic             busy_ff;
   logic             in_valid_ff;
   logic             in_valid_in;
   ucf_pkg::req_type req_ff;
   logic             rsp_strobe_ff;
   ucf_pkg::rsp_type rsp_ff;
   ucf_pkg::rsp_type rsp_in;

   assign busy        = busy_ff;
   assign in_valid_in = start && !busy_ff;
   assign rsp_in      = ucf_pkg::classify(req_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         in_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         in_valid_ff   <= in_valid_in;
         rsp_strobe_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         req_ff <= req_data;
      end
      if (in_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `UCF_ASSERT_NEXT(a_word_to_result, clock, reset, start && !busy, ##1 rsp_strobe)
   `UCF_ASSERT_IMPLY(a_strobe_has_source, clock, reset, rsp_strobe, $past(in_valid_ff))
   `UCF_ASSERT_IMPLY(a_graphic_printable, clock, reset,
                     rsp_strobe && rsp_data.is_graphic,
                     rsp_data.is_printable && !rsp_data.is_whitespace)
   `UCF_ASSERT_IMPLY(a_control_not_print, clock, reset,
                     rsp_strobe && rsp_data.is_control, !rsp_data.is_printable)
   `UCF_ASSERT_IMPLY(a_blank_is_space, clock, reset,
                     rsp_strobe && rsp_data.is_blank_char, rsp_data.is_whitespace)

endmodule

// ===== bench/tb_unicode_char_class_flags_top.sv =====
module tb_unicode_char_class_flags_top;

   localparam int unsigned STALL_LIMIT = 1000;
   localparam int unsigned DRAIN_CYCLES = 8;

   localparam int unsigned DECIMAL_BASE [36] = '{
      'h0660, 'h06F0, 'h07C0, 'h0966, 'h09E6, 'h0A66, 'h0AE6, 'h0B66,
      'h0BE6, 'h0C66, 'h0CE6, 'h0D66, 'h0DE6, 'h0E50, 'h0ED0, 'h0F20,
      'h1040, 'h1090, 'h17E0, 'h1810, 'h1946, 'h19D0, 'h1A80, 'h1A90,
      'h1B50, 'h1BB0, 'h1C40, 'h1C50, 'hA620, 'hA8D0, 'hA900, 'hA9D0,
      'hA9F0, 'hAA50, 'hABF0, 'hFF10
   };

   localparam int unsigned EDGE_POINTS [64] = '{
      'h09, 'h0D, 'h1F, 'h20, 'h21, 'h2F, 'h30, 'h39,
      'h3A, 'h40, 'h41, 'h46, 'h5A, 'h5B, 'h60, 'h61,
      'h66, 'h7A, 'h7B, 'h7E, 'h7F, 'h80, 'h9F, 'hA0,
      'hA1, 'hA7, 'hAB, 'hB6, 'hB7, 'hBB, 'hBF, 'h100,
      'h2AF, 'h370, 'h373, 'h376, 'h377, 'h37A, 'h37D, 'h37F,
      'h386, 'h387, 'h3FF, 'h400, 'h52F, 'h1680, 'h2000, 'h200A,
      'h200B, 'h200F, 'h2010, 'h2027, 'h2028, 'h2029, 'h202A, 'h202E,
      'h202F, 'h2030, 'h205E, 'h205F, 'h2060, 'h2064, 'h3000, 'hFEFF
   };

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   ucf_pkg::req_type req_data;
   logic             rsp_strobe;
   ucf_pkg::rsp_type rsp_data;

   ucf_pkg::rsp_type pending_flags[$];
   int unsigned      words_sent;
   int unsigned      flags_checked;
   int unsigned      mismatches;
   int unsigned      stall_cycles;

   unicode_char_class_flags_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit in_span(logic [20:0] c, int unsigned lo, int unsigned hi);
      return (c >= lo) && (c <= hi);
   endfunction

   function automatic ucf_pkg::rsp_type classify_point(ucf_pkg::req_type w);
      ucf_pkg::rsp_type f;
      logic [20:0]      c;
      bit               ascii;
      bit               alpha;
      bit               digit;
      bit               space;
      bit               control;
      bit               hidden;
      bit               print;
      c = w.code_point;
      ascii = c < 'h80;
      if (ascii) begin
         alpha = in_span(c, 'h41, 'h5A) || in_span(c, 'h61, 'h7A);
      end else begin
         alpha = w.has_upper_mapping || w.has_lower_mapping ||
                 in_span(c, 'h100, 'h2AF) || in_span(c, 'h370, 'h373) ||
                 in_span(c, 'h376, 'h377) || in_span(c, 'h37A, 'h37D) ||
                 (c == 'h37F) || in_span(c, 'h386, 'h386) ||
                 in_span(c, 'h388, 'h52F);
      end
      digit = in_span(c, 'h30, 'h39);
      foreach (DECIMAL_BASE[i]) begin
         if (in_span(c, DECIMAL_BASE[i], DECIMAL_BASE[i] + 9)) begin
            digit = 1'b1;
         end
      end
      if (ascii) begin
         space = (c == 'h20) || in_span(c, 'h09, 'h0D);
      end else begin
         space = (c == 'hA0) || (c == 'h1680) || in_span(c, 'h2000, 'h200A) ||
                 (c == 'h2028) || (c == 'h2029) || (c == 'h202F) ||
                 (c == 'h205F) || (c == 'h3000);
      end
      control = in_span(c, 'h00, 'h1F) || in_span(c, 'h7F, 'h9F);
      hidden = in_span(c, 'h200B, 'h200F) || in_span(c, 'h202A, 'h202E) ||
               in_span(c, 'h2060, 'h2064) || (c == 'hFEFF);
      print = !control && !hidden;
      f.is_letter          = alpha;
      f.is_decimal         = digit;
      f.is_letter_or_digit = alpha || digit;
      f.is_whitespace      = space;
      f.is_blank_char      = (c == 'h20) || (c == 'h09);
      f.is_control         = control;
      f.is_printable       = print;
      f.is_graphic         = print && !space;
      if (ascii) begin
         f.is_punctuation = in_span(c, 'h21, 'h2F) || in_span(c, 'h3A, 'h40) ||
                            in_span(c, 'h5B, 'h60) || in_span(c, 'h7B, 'h7E);
      end else begin
         f.is_punctuation = (c == 'hA1) || (c == 'hA7) || (c == 'hAB) ||
                            (c == 'hB6) || (c == 'hB7) || (c == 'hBB) ||
                            (c == 'hBF) || in_span(c, 'h2010, 'h2027) ||
                            in_span(c, 'h2030, 'h205E);
      end
      f.is_hex_digit = in_span(c, 'h30, 'h39) || in_span(c, 'h41, 'h46) ||
                       in_span(c, 'h61, 'h66);
      return f;
   endfunction

   task automatic compare_flag(string name, logic expected, logic actual);
      if (actual !== expected) begin
         $display("%0t mismatch on %s: expected %b, actual %b", $time, name,
                  expected, actual);
         mismatches++;
      end
   endtask

   // Results are checked before the word taken at the same edge is predicted.
   always @(posedge clock) begin
      ucf_pkg::rsp_type expected;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (pending_flags.size() == 0) begin
               $display("%0t unexpected result: expected none, actual %b", $time,
                        rsp_data);
               mismatches++;
            end else begin
               expected = pending_flags.pop_front();
               compare_flag("is_letter", expected.is_letter, rsp_data.is_letter);
               compare_flag("is_decimal", expected.is_decimal, rsp_data.is_decimal);
               compare_flag("is_letter_or_digit", expected.is_letter_or_digit,
                            rsp_data.is_letter_or_digit);
               compare_flag("is_whitespace", expected.is_whitespace,
                            rsp_data.is_whitespace);
               compare_flag("is_blank_char", expected.is_blank_char,
                            rsp_data.is_blank_char);
               compare_flag("is_control", expected.is_control, rsp_data.is_control);
               compare_flag("is_printable", expected.is_printable,
                            rsp_data.is_printable);
               compare_flag("is_graphic", expected.is_graphic, rsp_data.is_graphic);
               compare_flag("is_punctuation", expected.is_punctuation,
                            rsp_data.is_punctuation);
               compare_flag("is_hex_digit", expected.is_hex_digit,
                            rsp_data.is_hex_digit);
               flags_checked++;
            end
         end
         if (start && !busy) begin
            pending_flags.push_back(classify_point(req_data));
            words_sent++;
         end
         if ((rsp_strobe === 1'b1) || (start && !busy)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
      end
      $display("%0t watchdog: no word or result for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the word is taken,
   // with start still high so that a following word follows without a gap.
   task automatic present_word(logic [20:0] cp, bit up, bit low, int unsigned gap_odds);
      ucf_pkg::req_type w;
      w.code_point        = cp;
      w.has_upper_mapping = up;
      w.has_lower_mapping = low;
      if ((gap_odds != 0) && ($urandom_range(0, gap_odds - 1) == 0)) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      @(negedge clock);
   endtask

   task automatic settle_pipeline();
      start <= 1'b0;
      while (pending_flags.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic test_directed();
      logic [20:0] points [25] = '{
         21'h000000, 21'h000080, 21'h000530, 21'h000041, 21'h000009,
         21'h000020, 21'h00007F, 21'h00007A, 21'h00009F, 21'h0000A0,
         21'h0000A1, 21'h000066, 21'h000386, 21'h000387, 21'h00052F,
         21'h00017F, 21'h000660, 21'h00FF19, 21'h00200B, 21'h00FEFF,
         21'h002010, 21'h00205E, 21'h003000, 21'h1FFFFF, 21'h110000
      };
      for (int i = 0; i < 25; i++) begin
         present_word(points[i], i[0], i[1], 3);
      end
   endtask

   task automatic test_ascii_random();
      repeat (150) begin
         present_word(21'($urandom_range(0, 'h7F)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 4);
      end
   endtask

   task automatic test_boundary_random();
      int p;
      repeat (250) begin
         if ($urandom_range(0, 2) == 0) begin
            p = int'(DECIMAL_BASE[$urandom_range(0, 35)]) + $urandom_range(0, 11) - 1;
         end else begin
            p = int'(EDGE_POINTS[$urandom_range(0, 63)]) + $urandom_range(0, 4) - 2;
         end
         present_word(p[20:0], 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 6);
      end
   endtask

   task automatic test_wide_random();
      logic [31:0] r;
      repeat (150) begin
         r = $urandom;
         present_word(r[20:0], r[21], r[22], 3);
      end
   endtask

   task automatic test_stream_random();
      logic [31:0] r;
      repeat (100) begin
         r = $urandom;
         if (r[31]) begin
            r[20:0] = 21'(EDGE_POINTS[$urandom_range(0, 63)]);
         end else if (r[30]) begin
            r[20:0] = r[20:0] & 21'h00FFFF;
         end
         present_word(r[20:0], r[21], r[22], 0);
      end
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      words_sent    = 0;
      flags_checked = 0;
      mismatches    = 0;
      stall_cycles  = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      settle_pipeline();
      test_ascii_random();
      test_boundary_random();
      settle_pipeline();
      test_wide_random();
      test_stream_random();

      start <= 1'b0;
      while (pending_flags.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Classified %0d words and checked %0d results: directed extremes,",
               words_sent, flags_checked);
      $display("ASCII, range edges, digit blocks, full 21-bit points; %0d mismatches.",
               mismatches);
      if ((mismatches == 0) && (pending_flags.size() == 0)) begin
         $display("[ OK ] regression clean");
      end else begin
         if (pending_flags.size() != 0) begin
            $display("%0t %0d expected results never arrived", $time,
                     pending_flags.size());
         end
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ucf_pkg.sv
hw/rtl/unicode_char_class_flags_top.sv
bench/tb_unicode_char_class_flags_top.sv
